>>> rtl/dcth_pkg.sv
// ----------------------------------------------------------------------------
// dcth_pkg
// shared types and constants for the data channel table block
// ----------------------------------------------------------------------------
package dcth_pkg;

    localparam int MAX_CHANNELS_DEF = 16;
    localparam int MAX_LABEL_DEF    = 64;
    localparam int HEADER_BYTES     = 4;
    localparam int RESULT_LIMIT     = 16;
    localparam int NUM_IDS          = 256;
    localparam int ENTRY_W          = 10;
    localparam int LABEL_W          = 6;

    // request codes
    localparam logic [2:0] REQ_RX     = 3'd0;
    localparam logic [2:0] REQ_CREATE = 3'd1;
    localparam logic [2:0] REQ_CLOSE  = 3'd2;
    localparam logic [2:0] REQ_SEND   = 3'd3;
    localparam logic [2:0] REQ_LINKUP = 3'd4;
    localparam logic [2:0] REQ_CLEAR  = 3'd5;

    // channel states
    localparam logic [1:0] ST_CONNECTING = 2'd0;
    localparam logic [1:0] ST_OPEN       = 2'd1;
    localparam logic [1:0] ST_CLOSING    = 2'd2;
    localparam logic [1:0] ST_CLOSED     = 2'd3;

    // application events
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_OPENED = 3'd1;
    localparam logic [2:0] EV_CLOSED = 3'd2;
    localparam logic [2:0] EV_NEW    = 3'd3;
    localparam logic [2:0] EV_DATA   = 3'd4;

    // status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_FULL    = 2'd2;

    // config register indexes
    localparam logic [2:0] CFG_OPEN  = 3'd0;
    localparam logic [2:0] CFG_ACK   = 3'd1;
    localparam logic [2:0] CFG_DATA  = 3'd2;
    localparam logic [2:0] CFG_CLOSE = 3'd3;
    localparam logic [2:0] CFG_MAX   = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  chan_id;
        logic [7:0]  wire_type;
        logic [15:0] payload_length;
        logic [16:0] frame_length;
        logic        use_given_id;
        logic [15:0] label_length;
    } t_req;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_type;
        logic [7:0]  send_channel;
        logic [15:0] send_length;
        logic [2:0]  event_kind;
        logic [7:0]  event_channel;
        logic [15:0] event_length;
        logic [1:0]  status;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [2:0]  idx;
        logic [15:0] data;
    } t_cfg;

endpackage

>>> rtl/dcth_if.sv
// ----------------------------------------------------------------------------
// dcth_if
// generic valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface dcth_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/data_channel_table_handshake.sv
// ----------------------------------------------------------------------------
// data_channel_table_handshake
// channel table with open/ack handshake, one event in, one or more words out
// ----------------------------------------------------------------------------
// Usage: i_req carries one event word (rx header, create, close, send,
// link up, clear all). o_res returns the result words of that event, the
// final one flagged by last. i_cfg writes the wire codes and the maximum
// message size; write only while the block is idle.
// An ordinary event reads its table entry, then writes back and presents
// its result; no new event is accepted until that result word has been
// taken.
// Link up sweeps all 256 entries one per cycle through the table ram,
// pausing for output stalls and to reread an entry when a held word is
// offered; up to 16 open words leave on the way, each held back until the
// next one is found so that the final word carries last.
// Clear all walks the table too. After reset a clearing pass runs before
// the first event is accepted.
// A stalled receiver holds the result register; the sweep waits with it.
// The table ram's single read port sets the rate.
// ----------------------------------------------------------------------------
module data_channel_table_handshake #(
    parameter int MAX_CHANNELS = dcth_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_LABEL    = dcth_pkg::MAX_LABEL_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dcth_if.sink   i_req,
    dcth_if.source o_res,
    dcth_if.sink   i_cfg
);
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int LBL_W = $clog2(MAX_LABEL);
    localparam int EW    = 4 + LBL_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_EXEC  = 6'b001000,
        S_SWEEP = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    dcth_pkg::t_req    r_req;
    logic [7:0]        r_code_open, r_code_ack, r_code_data, r_code_close;
    logic [15:0]       r_max;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [8:0]        r_auto, n_auto;
    logic              r_link, n_link;
    logic [8:0]        r_ptr, n_ptr;     // sweep/clear address, bit 8 marks done
    logic [4:0]        r_nres, n_nres;   // words found during a link-up sweep
    logic              r_sweep_rd;       // read data of r_ptr-1 valid
    logic              r_held, n_held;   // r_res holds an open word not yet offered
    dcth_pkg::t_res    r_res, n_res;
    logic              r_res_v, n_res_v;

    logic              we;
    logic [7:0]        waddr, raddr;
    logic [EW-1:0]     wdata, rdata;

    dcth_ram #(.WIDTH(EW), .DEPTH(dcth_pkg::NUM_IDS)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // entry fields: {valid, state[1:0], local, label}
    logic             e_valid, e_local;
    logic [1:0]       e_st;
    logic [LBL_W-1:0] e_lbl;
    assign e_valid = rdata[EW-1];
    assign e_st    = rdata[EW-2 -: 2];
    assign e_local = rdata[LBL_W];
    assign e_lbl   = rdata[LBL_W-1:0];

    function automatic logic [LBL_W-1:0] clip(input logic [15:0] v);
        if (v > 16'(MAX_LABEL - 1)) begin
            return LBL_W'(MAX_LABEL - 1);
        end
        return v[LBL_W-1:0];
    endfunction

    assign i_req.ready = (r_state == S_IDLE) && !r_res_v;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid   = r_res_v;
    assign o_res.payload = r_res;

    logic [7:0]  cid;
    logic [16:0] need;
    logic [7:0]  new_id;
    logic [LBL_W-1:0] lbl_c;
    logic        sw_hit;
    assign cid    = r_req.chan_id;
    assign need   = 17'(dcth_pkg::HEADER_BYTES) + {1'b0, r_req.payload_length};
    assign new_id = r_req.use_given_id ? cid : r_auto[7:0];
    assign lbl_c  = clip(r_req.label_length);
    assign sw_hit = e_valid && e_local && (e_st == dcth_pkg::ST_CONNECTING)
                    && ({{(16-LBL_W){1'b0}}, e_lbl} <= r_max);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_auto  = r_auto;
        n_link  = r_link;
        n_ptr   = r_ptr;
        n_nres  = r_nres;
        n_held  = r_held;
        n_res   = r_res;
        n_res_v = r_res_v;
        we      = 1'b0;
        waddr   = cid;
        wdata   = '0;
        raddr   = cid;
        if (o_res.valid && o_res.ready) begin
            n_res_v = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_ptr[7:0];
                n_ptr = r_ptr + 9'd1;
                if (r_ptr[8] || r_ptr == 9'd255) begin
                    n_state = r_req.req_type == dcth_pkg::REQ_CLEAR && r_res_v
                              ? S_OUT : S_IDLE;
                    n_ptr   = '0;
                end
            end
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_res   = '0;
                n_res.last = 1'b1;
                n_res_v = 1'b1;
                n_state = S_OUT;
                unique case (r_req.req_type)
                    dcth_pkg::REQ_RX: begin
                        if (r_req.frame_length < 17'(dcth_pkg::HEADER_BYTES)
                            || need > r_req.frame_length) begin
                            n_res.status = dcth_pkg::STS_INVALID;
                        end else if (r_req.wire_type == r_code_open) begin
                            if (e_valid) begin
                                we    = 1'b1;
                                wdata = {1'b1, dcth_pkg::ST_OPEN, e_local, e_lbl};
                                n_res.send_valid    = 1'b1;
                                n_res.send_type     = r_code_ack;
                                n_res.send_channel  = cid;
                                n_res.event_kind    = dcth_pkg::EV_OPENED;
                                n_res.event_channel = cid;
                            end else if (r_count >= CNT_W'(MAX_CHANNELS)) begin
                                n_res.status = dcth_pkg::STS_FULL;
                            end else begin
                                we      = 1'b1;
                                wdata   = {1'b1, dcth_pkg::ST_OPEN, 1'b0,
                                           clip(r_req.payload_length)};
                                n_count = r_count + 1'b1;
                                n_res.send_valid    = 1'b1;
                                n_res.send_type     = r_code_ack;
                                n_res.send_channel  = cid;
                                n_res.event_kind    = dcth_pkg::EV_NEW;
                                n_res.event_channel = cid;
                            end
                        end else if (r_req.wire_type == r_code_ack) begin
                            if (e_valid && e_st == dcth_pkg::ST_CONNECTING) begin
                                we    = 1'b1;
                                wdata = {1'b1, dcth_pkg::ST_OPEN, e_local, e_lbl};
                                n_res.event_kind    = dcth_pkg::EV_OPENED;
                                n_res.event_channel = cid;
                            end
                        end else if (r_req.wire_type == r_code_data) begin
                            if (e_valid && e_st == dcth_pkg::ST_OPEN) begin
                                n_res.event_kind    = dcth_pkg::EV_DATA;
                                n_res.event_channel = cid;
                                n_res.event_length  = r_req.payload_length;
                            end
                        end else if (r_req.wire_type == r_code_close) begin
                            if (e_valid && e_st != dcth_pkg::ST_CLOSED) begin
                                we    = 1'b1;
                                wdata = {1'b1, dcth_pkg::ST_CLOSED, e_local, e_lbl};
                                n_res.event_kind    = dcth_pkg::EV_CLOSED;
                                n_res.event_channel = cid;
                            end
                        end
                    end
                    dcth_pkg::REQ_CREATE: begin
                        // entry read at the given id; auto ids were read at r_auto
                        if (r_count >= CNT_W'(MAX_CHANNELS)
                            || (!r_req.use_given_id && r_auto[8])) begin
                            n_res.status = dcth_pkg::STS_FULL;
                        end else begin
                            we    = 1'b1;
                            waddr = new_id;
                            wdata = {1'b1, dcth_pkg::ST_CONNECTING, 1'b1, lbl_c};
                            if (!e_valid) begin
                                n_count = r_count + 1'b1;
                            end
                            if (!r_req.use_given_id) begin
                                n_auto = r_auto + 9'd2;
                            end
                            n_res.event_channel = new_id;
                            if (r_link && {{(16-LBL_W){1'b0}}, lbl_c} <= r_max) begin
                                n_res.send_valid   = 1'b1;
                                n_res.send_type    = r_code_open;
                                n_res.send_channel = new_id;
                                n_res.send_length  = 16'(lbl_c);
                            end
                        end
                    end
                    dcth_pkg::REQ_CLOSE: begin
                        if (!e_valid) begin
                            n_res.status = dcth_pkg::STS_INVALID;
                        end else if (e_st != dcth_pkg::ST_CLOSED) begin
                            we    = 1'b1;
                            wdata = {1'b1, dcth_pkg::ST_CLOSED, e_local, e_lbl};
                            n_res.event_kind    = dcth_pkg::EV_CLOSED;
                            n_res.event_channel = cid;
                            if (e_st == dcth_pkg::ST_OPEN) begin
                                n_res.send_valid   = 1'b1;
                                n_res.send_type    = r_code_close;
                                n_res.send_channel = cid;
                            end
                        end
                    end
                    dcth_pkg::REQ_SEND: begin
                        if (!e_valid || e_st != dcth_pkg::ST_OPEN
                            || r_req.payload_length > r_max) begin
                            n_res.status = dcth_pkg::STS_INVALID;
                        end else begin
                            n_res.send_valid   = 1'b1;
                            n_res.send_type    = r_code_data;
                            n_res.send_channel = cid;
                            n_res.send_length  = r_req.payload_length;
                        end
                    end
                    dcth_pkg::REQ_LINKUP: begin
                        n_link  = 1'b1;
                        n_res_v = 1'b0;
                        n_ptr   = '0;
                        n_nres  = '0;
                        n_held  = 1'b0;
                        n_state = S_SWEEP;
                        raddr   = 8'd0;
                    end
                    dcth_pkg::REQ_CLEAR: begin
                        n_count = '0;
                        n_link  = 1'b0;
                        n_ptr   = '0;
                        n_state = S_CLEAR;
                    end
                    default: begin
                        n_res.status = dcth_pkg::STS_INVALID;
                    end
                endcase
            end
            S_SWEEP: begin
                // rdata holds entry r_ptr-1 when r_sweep_rd
                raddr = r_ptr[7:0];
                if (!r_res_v || (o_res.valid && o_res.ready)) begin
                    if (r_held && r_sweep_rd && sw_hit
                        && r_nres != 5'(dcth_pkg::RESULT_LIMIT)) begin
                        // another open word follows: offer the held one, judge again
                        n_res_v = 1'b1;
                        n_held  = 1'b0;
                        raddr   = 8'(r_ptr - 9'd1);
                    end else begin
                        if (r_sweep_rd && sw_hit
                            && r_nres != 5'(dcth_pkg::RESULT_LIMIT)) begin
                            n_res   = '0;
                            n_res.send_valid   = 1'b1;
                            n_res.send_type    = r_code_open;
                            n_res.send_channel = 8'(r_ptr - 9'd1);
                            n_res.send_length  = 16'(e_lbl);
                            n_held  = 1'b1;
                            n_nres  = r_nres + 5'd1;
                        end
                        if (r_ptr == 9'd256 || (r_ptr[8] && r_sweep_rd)) begin
                            // last entry judged this cycle
                            if (n_nres == '0) begin
                                n_res = '0;
                            end
                            n_res.last = 1'b1;
                            n_res_v    = 1'b1;
                            n_held     = 1'b0;
                            n_state    = S_OUT;
                        end else begin
                            n_ptr = r_ptr + 9'd1;
                        end
                    end
                end else begin
                    // stalled: reread the pending entry
                    raddr = 8'(r_ptr - 9'd1);
                end
            end
            S_OUT: begin
                if (!n_res_v) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE && i_req.valid) begin
            raddr = (i_req.payload.req_type == dcth_pkg::REQ_CREATE
                     && !i_req.payload.use_given_id) ? r_auto[7:0]
                                                     : i_req.payload.chan_id;
        end else if (r_state == S_READ) begin
            raddr = (r_req.req_type == dcth_pkg::REQ_CREATE && !r_req.use_given_id)
                    ? r_auto[7:0] : cid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_count      <= '0;
            r_auto       <= '0;
            r_link       <= 1'b0;
            r_ptr        <= '0;
            r_nres       <= '0;
            r_held       <= 1'b0;
            r_res_v      <= 1'b0;
            r_sweep_rd   <= 1'b0;
            r_code_open  <= 8'd0;
            r_code_ack   <= 8'd1;
            r_code_data  <= 8'd2;
            r_code_close <= 8'd3;
            r_max        <= 16'd16384;
            r_req        <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_auto     <= n_auto;
            r_link     <= n_link;
            r_ptr      <= n_ptr;
            r_nres     <= n_nres;
            r_held     <= n_held;
            r_res_v    <= n_res_v;
            r_sweep_rd <= (n_state == S_SWEEP) && (r_state == S_SWEEP);
            if (i_req.valid && i_req.ready) begin
                r_req <= i_req.payload;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.payload.idx)
                    dcth_pkg::CFG_OPEN:  r_code_open  <= i_cfg.payload.data[7:0];
                    dcth_pkg::CFG_ACK:   r_code_ack   <= i_cfg.payload.data[7:0];
                    dcth_pkg::CFG_DATA:  r_code_data  <= i_cfg.payload.data[7:0];
                    dcth_pkg::CFG_CLOSE: r_code_close <= i_cfg.payload.data[7:0];
                    dcth_pkg::CFG_MAX:   r_max        <= i_cfg.payload.data;
                    default: ;
                endcase
            end
        end
        r_res <= n_res;
    end

    // assertions
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CHANNELS))
        else $error("channel count above limit");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready)
        else $error("request accepted while busy");
    a_auto_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_auto[0])
        else $error("automatic id odd");
    a_sweep_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= 5'(dcth_pkg::RESULT_LIMIT))
        else $error("sweep sent too many words");
endmodule

>>> rtl/dcth_ram.sv
// ----------------------------------------------------------------------------
// dcth_ram
// simple dual port synchronous ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dcth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
